>>> rtl/sspg_pkg.sv
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types, constants and helpers for the sequenced servo pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sspg_pkg;

	localparam int WIDTH_W   = 16;  // pulse width, delay and frame length
	localparam int ADC_W     = 10;  // converter reading
	localparam int SEL_W     = 3;   // servo select field
	localparam int LINES_W   = 4;   // servo line field of a result
	localparam int PHASE_W   = 3;   // phase field of a result
	localparam int CFG_IDX_W = 2;   // configuration register index

	// Full-scale converter count is 2^ADC_SHIFT - 1.
	localparam int ADC_SHIFT = 10;
	localparam int ADC_FULL  = (1 << ADC_SHIFT) - 1;
	localparam int PROD_W    = ADC_W + WIDTH_W;

	localparam int SERVO_COUNT_DEF = 4;

	localparam logic [WIDTH_W-1:0] RST_MIN_WIDTH   = WIDTH_W'(2000);
	localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH   = WIDTH_W'(4000);
	localparam logic [WIDTH_W-1:0] RST_FRAME_TICKS = WIDTH_W'(40000);
	localparam logic [WIDTH_W-1:0] RST_MID_WIDTH   = WIDTH_W'(3000);
	localparam logic [WIDTH_W-1:0] FIRST_DELAY     = WIDTH_W'(100);

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SET  = 2'd1,
		FUNC_ADC  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_WIDTH   = 2'd0,
		CFG_MAX_WIDTH   = 2'd1,
		CFG_FRAME_TICKS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		func_t              func;
		logic [SEL_W-1:0]   servo_sel;
		logic [WIDTH_W-1:0] width_value;
		logic [ADC_W-1:0]   adc_count;
	} item_t;

	typedef struct packed {
		logic [LINES_W-1:0] servo_lines;
		logic [PHASE_W-1:0] phase_now;
		logic               frame_begin;
	} result_t;

	// Raise to the minimum first, then lower to the maximum, so that a
	// minimum above the maximum yields the maximum.
	function automatic logic [WIDTH_W-1:0] clamp_width(
		input logic [WIDTH_W:0]   v,
		input logic [WIDTH_W-1:0] lo,
		input logic [WIDTH_W-1:0] hi
	);
		logic [WIDTH_W:0] r;
		r = (v < {1'b0, lo}) ? {1'b0, lo} : v;
		if (r > {1'b0, hi}) begin
			r = {1'b0, hi};
		end
		return r[WIDTH_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/sspg_adc_scale.sv
// ----------------------------------------------------------------------------
// sspg_adc_scale
// Turns a registered count-times-span product into a clamped pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module sspg_adc_scale
	import sspg_pkg::*;
(
	input  wire logic [PROD_W-1:0]  product,
	input  wire logic [WIDTH_W-1:0] min_width,
	input  wire logic [WIDTH_W-1:0] max_width,
	output logic      [WIDTH_W-1:0] width
);

	localparam int Y_W = PROD_W + 1;
	localparam int Q_W = Y_W - ADC_SHIFT;

	logic [Y_W-1:0]     sum_y;
	logic [Q_W-1:0]     q_est;
	logic [Y_W-1:0]     q_times_full;
	logic [Y_W-1:0]     rem;
	logic [Q_W-1:0]     quot;
	logic [WIDTH_W:0]   raw;

	// Division by 2^k - 1 as a short geometric series of shifts. The estimate
	// never overshoots and falls short by at most one, which the remainder
	// check puts right.
	always_comb begin
		sum_y        = Y_W'(product) + Y_W'(product >> ADC_SHIFT)
		             + Y_W'(product >> (2 * ADC_SHIFT));
		q_est        = sum_y[Y_W-1:ADC_SHIFT];
		q_times_full = {q_est, {ADC_SHIFT{1'b0}}} - Y_W'(q_est);
		rem          = Y_W'(product) - q_times_full;
		quot         = (rem >= Y_W'(ADC_FULL)) ? q_est + Q_W'(1) : q_est;
		raw          = {1'b0, min_width} + quot[WIDTH_W:0];
		width        = clamp_width(raw, min_width, max_width);
	end

endmodule

`default_nettype wire

>>> rtl/sequenced_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// sequenced_servo_pulse_generator
// Multiplexed servo pulse sequencer with per-servo width registers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item_t   (func, select, width, count)
// result    out        result_valid / result_stall result_t (lines, phase, frame start)
// cfg       in         cfg_we                      cfg_index, cfg_data
//
// The sequencing logic sits between the input register and the result
// register, so a word taken into the input register reaches the result
// register when both stages advance; a new word may be taken every cycle. The
// direct width clamp and the converter multiply sit before the input register;
// the divide by full scale, its clamp and the width store sit after it.
// Reset loads the state with its defaults; the first phase starts on the 100th tick.
// A stalled result holds both stages, and item_stall rises only while the
// input stage is full and cannot move on.
//
`default_nettype none

module sequenced_servo_pulse_generator
	import sspg_pkg::*;
#(
	parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,

	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WIDTH_W-1:0]   cfg_data
);

	// Phase runs from 0 to SERVO_COUNT, the last being the frame gap.
	localparam int PH_W  = $clog2(SERVO_COUNT + 1);
	localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam int POS_W = PH_W + 1;
	localparam int SUM_W = WIDTH_W + $clog2(SERVO_COUNT);

	// Configuration registers.
	logic [WIDTH_W-1:0] min_width_q;
	logic [WIDTH_W-1:0] max_width_q;
	logic [WIDTH_W-1:0] frame_ticks_q;

	// Input stage.
	logic               s1_valid_q;
	func_t              func_s1;
	logic [SEL_W-1:0]   sel_s1;
	logic [WIDTH_W-1:0] wclamp_s1;
	logic [PROD_W-1:0]  prod_s1;

	// Sequencer state. The width store is kept rotated so that the width of
	// the next servo phase always sits at position 0.
	logic [WIDTH_W-1:0]     delay_q;
	logic [PH_W-1:0]        next_phase_q;
	logic [SERVO_COUNT-1:0] lines_q;
	logic [WIDTH_W-1:0]     widths_q [SERVO_COUNT];
	logic [SUM_W-1:0]       sum_q;

	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept_in;
	logic                   advance;
	logic [WIDTH_W-1:0]     span;
	logic [WIDTH_W-1:0]     adc_width;
	logic [WIDTH_W-1:0]     new_width;
	logic [WIDTH_W-1:0]     gap_len;
	logic                   sel_ok;
	logic [PH_W-1:0]        rot_off;
	logic [POS_W-1:0]       sel_pos;
	logic [POS_W-1:0]       wpos_full;
	logic [IDX_W-1:0]       wpos;
	logic [WIDTH_W-1:0]     old_width;

	logic [WIDTH_W-1:0]     delay_n;
	logic [PH_W-1:0]        next_n;
	logic [SERVO_COUNT-1:0] lines_n;
	logic                   begin_n;
	logic                   rotate;
	logic                   store;
	logic [PH_W-1:0]        phase_n;

	// ------------------------------------------------------------------
	// Handshakes. Both stages move together whenever the result register is
	// empty or being drained.
	// ------------------------------------------------------------------
	assign advance      = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall   = s1_valid_q && !advance;
	assign accept_in    = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------
	// Configuration writes. Indices past the last register are dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q   <= RST_MIN_WIDTH;
			max_width_q   <= RST_MAX_WIDTH;
			frame_ticks_q <= RST_FRAME_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_WIDTH:   min_width_q   <= cfg_data;
				CFG_MAX_WIDTH:   max_width_q   <= cfg_data;
				CFG_FRAME_TICKS: frame_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input stage: the direct width is clamped and the converter count is
	// multiplied by the span here, so the next stage need not multiply.
	// An inverted range counts as a zero span.
	// ------------------------------------------------------------------
	assign span = (max_width_q >= min_width_q) ? max_width_q - min_width_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept_in) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_s1   <= item.func;
			sel_s1    <= item.servo_sel;
			wclamp_s1 <= clamp_width({1'b0, item.width_value}, min_width_q, max_width_q);
			prod_s1   <= PROD_W'(item.adc_count) * PROD_W'(span);
		end
	end

	sspg_adc_scale u_adc_scale (
		.product   (prod_s1),
		.min_width (min_width_q),
		.max_width (max_width_q),
		.width     (adc_width)
	);

	// ------------------------------------------------------------------
	// Sequencing stage.
	// ------------------------------------------------------------------
	assign new_width = (func_s1 == FUNC_ADC) ? adc_width : wclamp_s1;

	// When the widths add up to the frame or more, the gap shrinks to a
	// single tick.
	assign gap_len = (sum_q >= SUM_W'(frame_ticks_q))
		? WIDTH_W'(1) : frame_ticks_q - sum_q[WIDTH_W-1:0];

	// Servo s lives at position (s - offset) mod SERVO_COUNT, where the offset
	// is the number of servo phases already entered in this frame.
	assign sel_ok    = {1'b0, sel_s1} < (SEL_W + 1)'(SERVO_COUNT);
	assign rot_off   = (next_phase_q == PH_W'(SERVO_COUNT)) ? '0 : next_phase_q;
	assign sel_pos   = POS_W'(sel_s1);
	assign wpos_full = (sel_pos >= POS_W'(rot_off))
		? sel_pos - POS_W'(rot_off)
		: sel_pos + POS_W'(SERVO_COUNT) - POS_W'(rot_off);
	assign wpos      = wpos_full[IDX_W-1:0];
	assign old_width = widths_q[wpos];

	always_comb begin
		delay_n = delay_q;
		next_n  = next_phase_q;
		lines_n = lines_q;
		begin_n = 1'b0;
		rotate  = 1'b0;
		store   = 1'b0;
		unique case (func_s1)
			FUNC_TICK: begin
				if (delay_q > WIDTH_W'(1)) begin
					delay_n = delay_q - WIDTH_W'(1);
				end else if (next_phase_q < PH_W'(SERVO_COUNT)) begin
					// A stored width of zero reloads zero, which ends the
					// phase on the next tick just as a width of one would.
					lines_n = SERVO_COUNT'(1) << next_phase_q;
					delay_n = widths_q[0];
					next_n  = next_phase_q + PH_W'(1);
					begin_n = (next_phase_q == '0);
					rotate  = 1'b1;
				end else begin
					lines_n = '0;
					delay_n = gap_len;
					next_n  = '0;
				end
			end
			FUNC_SET,
			FUNC_ADC: begin
				store = sel_ok;
			end
			FUNC_NONE: ;
		endcase
	end

	// The phase being timed is the one before the next phase, with the gap
	// reported before the first phase after reset.
	assign phase_n = (next_n == '0) ? PH_W'(SERVO_COUNT) : next_n - PH_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q      <= FIRST_DELAY;
			next_phase_q <= '0;
			lines_q      <= '0;
			sum_q        <= SUM_W'(SERVO_COUNT * RST_MID_WIDTH);
			for (int j = 0; j < SERVO_COUNT; j++) begin
				widths_q[j] <= RST_MID_WIDTH;
			end
		end else if (advance) begin
			delay_q      <= delay_n;
			next_phase_q <= next_n;
			lines_q      <= lines_n;
			if (rotate) begin
				for (int j = 0; j < SERVO_COUNT; j++) begin
					widths_q[j] <= widths_q[(j + 1) % SERVO_COUNT];
				end
			end else if (store) begin
				widths_q[wpos] <= new_width;
				sum_q          <= sum_q - SUM_W'(old_width) + SUM_W'(new_width);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.servo_lines <= LINES_W'(lines_n);
			result_q.phase_now   <= PHASE_W'(phase_n);
			result_q.frame_begin <= begin_n;
		end
	end

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_phase_q <= PH_W'(SERVO_COUNT))
		else $error("next phase beyond the frame gap");

	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lines_q))
		else $error("more than one servo line high");

	a_line_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(lines_q != '0) |-> (next_phase_q != '0))
		else $error("servo line high while next phase is the first");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.frame_begin)
		|-> (result_q.servo_lines[0] && result_q.phase_now == '0))
		else $error("frame start without servo 0 pulse");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && result_valid_q && result_stall)
		|=> ($stable(delay_q) && $stable(next_phase_q) && $stable(lines_q)))
		else $error("sequencer moved while the result was stalled");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequenced servo pulse generator. A scoreboard
// class keeps its own copy of the frame sequencer, predicts one result for
// every word taken and compares the results as they leave the block, under
// random bursts, receiver stalls and several register settings.
// ----------------------------------------------------------------------------

module tb_top;

	import sspg_pkg::*;

	localparam int SERVOS = SERVO_COUNT_DEF;

	// ------------------------------------------------------------------------
	// Scoreboard: a software copy of the sequencer plus the queue of results
	// that the block still owes us.
	// ------------------------------------------------------------------------
	class servo_frame_board;
		logic [WIDTH_W-1:0] min_w, max_w, frame_len;
		logic [WIDTH_W-1:0] countdown;
		logic [2:0]         upcoming;
		logic [WIDTH_W-1:0] widths [SERVOS];
		logic [LINES_W-1:0] lines;
		result_t            awaited [$];
		int unsigned        errors, words, frames, short_gaps;

		function new();
			min_w     = RST_MIN_WIDTH;
			max_w     = RST_MAX_WIDTH;
			frame_len = RST_FRAME_TICKS;
			countdown = FIRST_DELAY;
			upcoming  = 3'd0;
			lines     = '0;
			foreach (widths[i]) widths[i] = RST_MID_WIDTH;
			errors = 0; words = 0; frames = 0; short_gaps = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [WIDTH_W-1:0] v);
			case (idx)
				CFG_MIN_WIDTH:   min_w = v;
				CFG_MAX_WIDTH:   max_w = v;
				CFG_FRAME_TICKS: frame_len = v;
				default: ;
			endcase
		endfunction

		// The floor is applied first, so a floor above the ceiling gives the ceiling.
		function logic [WIDTH_W-1:0] fit_width(int unsigned v);
			if (v < min_w) v = min_w;
			if (v > max_w) v = max_w;
			return v[WIDTH_W-1:0];
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_word(item_t w);
			logic        begin_now;
			int unsigned span, total;
			result_t     exp_res;
			begin_now = 1'b0;
			words++;
			case (w.func)
				FUNC_TICK: begin
					if (countdown > 1) begin
						countdown = countdown - 1'b1;
					end else if (upcoming < SERVOS) begin
						// A servo pulse: only this line is high for its width.
						lines     = LINES_W'(1 << upcoming);
						countdown = widths[upcoming];
						begin_now = (upcoming == 3'd0);
						upcoming  = upcoming + 1'b1;
					end else begin
						// The gap fills the rest of the frame, but never less than a tick.
						total = 0;
						foreach (widths[i]) total += widths[i];
						lines = '0;
						if (total >= frame_len) begin
							countdown = 1;
							short_gaps++;
						end else begin
							countdown = WIDTH_W'(frame_len - total);
						end
						upcoming = 3'd0;
					end
				end
				FUNC_SET: begin
					if (w.servo_sel < SERVOS) widths[w.servo_sel] = fit_width(w.width_value);
				end
				FUNC_ADC: begin
					span = (max_w >= min_w) ? 32'(max_w) - 32'(min_w) : 0;
					if (w.servo_sel < SERVOS)
						widths[w.servo_sel] = fit_width(32'(min_w)
							+ (32'(w.adc_count) * span) / ADC_FULL);
				end
				default: ;
			endcase
			if (begin_now) frames++;
			exp_res.servo_lines = lines;
			exp_res.phase_now   = PHASE_W'((32'(upcoming) + SERVOS) % (SERVOS + 1));
			exp_res.frame_begin = begin_now;
			awaited.push_back(exp_res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: lines %0h phase %0d begin %0b",
					got.servo_lines, got.phase_now, got.frame_begin);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.servo_lines !== want.servo_lines) begin
				$error("servo_lines: expected %0h, got %0h", want.servo_lines, got.servo_lines);
				errors++;
			end
			if (got.phase_now !== want.phase_now) begin
				$error("phase_now: expected %0d, got %0d", want.phase_now, got.phase_now);
				errors++;
			end
			if (got.frame_begin !== want.frame_begin) begin
				$error("frame_begin: expected %0b, got %0b", want.frame_begin, got.frame_begin);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and the block itself.
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WIDTH_W-1:0]   cfg_data;

	servo_frame_board board;
	int unsigned      settings_run;

	sequenced_servo_pulse_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A ceiling on the run: if it is reached, the run fails.
	initial begin
		#(64'd10_000_000);
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sender side. Every task is entered and left at a falling edge, and each
	// falling edge sees at most one assignment to item_valid.
	// ------------------------------------------------------------------------
	function automatic item_t make_item(func_t f, int unsigned sel, int unsigned wv,
		int unsigned adc);
		item_t w;
		w.func        = f;
		w.servo_sel   = SEL_W'(sel);
		w.width_value = WIDTH_W'(wv);
		w.adc_count   = ADC_W'(adc);
		return w;
	endfunction

	// The word is offered until the block takes it; the payload stays put
	// while the input is stalled.
	task automatic send_word(input item_t w);
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		board.note_word(w);
		@(negedge clk);
	endtask

	function automatic item_t random_word(int unsigned tick_pct);
		item_t       w;
		int unsigned pick;
		w = make_item(FUNC_TICK, 0, 0, 0);
		pick = $urandom_range(99);
		if ($urandom_range(99) < tick_pct) w.func = FUNC_TICK;
		else if (pick < 45) w.func = FUNC_SET;
		else if (pick < 85) w.func = FUNC_ADC;
		else w.func = FUNC_NONE;
		// Mostly real servos; now and then one of the indices that do not exist.
		w.servo_sel = ($urandom_range(4) == 0) ? SEL_W'($urandom_range(7, 4))
			: SEL_W'($urandom_range(SERVOS - 1));
		case ($urandom_range(3))
			0: w.width_value = WIDTH_W'($urandom);
			1: w.width_value = WIDTH_W'($urandom_range(24));
			2: w.width_value = $urandom_range(1) ? '1 : '0;
			default: w.width_value = WIDTH_W'($urandom_range(120));
		endcase
		case ($urandom_range(3))
			0: w.adc_count = '0;
			1: w.adc_count = '1;
			default: w.adc_count = ADC_W'($urandom);
		endcase
		return w;
	endfunction

	// Random words in bursts of random length with random gaps between them.
	// Now and then all four widths are reprogrammed in a row, as firmware would.
	task automatic send_random(input int unsigned count, input int unsigned tick_pct);
		int unsigned sent, burst, gap;
		sent  = 0;
		burst = 0;
		while (sent < count) begin
			if (burst == 0) begin
				burst = $urandom_range(24, 1);
				gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(7, 1);
				if (gap != 0) begin
					item_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			if ($urandom_range(19) == 0) begin
				for (int s = 0; s < SERVOS; s++) begin
					send_word(make_item(func_t'((s % 2) ? FUNC_ADC : FUNC_SET), s,
						$urandom_range(64), $urandom_range(1023)));
				end
				sent += SERVOS;
			end else begin
				send_word(random_word(tick_pct));
				sent++;
			end
			burst--;
		end
		item_valid <= 1'b0;
	endtask

	// Registers only change once every owed result has come back and the
	// pipeline has had time to drain.
	task automatic set_and_run(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi,
		input logic [WIDTH_W-1:0] frame, input int unsigned count,
		input int unsigned tick_pct);
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_WIDTH;
		cfg_data  <= lo;
		board.write_reg(CFG_MIN_WIDTH, lo);
		@(negedge clk);
		cfg_index <= CFG_MAX_WIDTH;
		cfg_data  <= hi;
		board.write_reg(CFG_MAX_WIDTH, hi);
		@(negedge clk);
		cfg_index <= CFG_FRAME_TICKS;
		cfg_data  <= frame;
		board.write_reg(CFG_FRAME_TICKS, frame);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
		send_random(count, tick_pct);
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: it stalls on a pattern of its own that it redraws as it
	// runs, with one long hold-off early on so that the block fills up and
	// has to stall its input, and the odd shorter hold-off later.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int unsigned cycle, mode;
		logic [7:0]  mask;
		logic        held_once;
		result_stall = 1'b0;
		cycle     = 0;
		mode      = 0;
		mask      = 8'hA5;
		held_once = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycle % 64 == 0) begin
				mode = $urandom_range(3);
				mask = 8'($urandom);
			end
			cycle++;
			if (!held_once && board.words >= 400) begin
				held_once = 1'b1;
				result_stall <= 1'b1;
				repeat (79) @(negedge clk);
			end else if ($urandom_range(499) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(40, 20)) @(negedge clk);
			end else begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(9) < 3);
					2: result_stall <= mask[cycle % 8];
					default: result_stall <= ($urandom_range(9) < 7);
				endcase
			end
		end
	end

	// Results are taken at the rising edge where valid is high and stall low.
	initial begin : result_monitor
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) board.check_result(result);
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		board        = new();
		settings_run = 1;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_MIN_WIDTH;
		cfg_data     = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the reset settings: the phase reads as the gap
		// until the first pulse, widths are clamped at both ends, the converter
		// is driven to zero and full scale, absent servos and the unused
		// function change nothing.
		send_word(make_item(FUNC_TICK, 0, 0, 0));
		send_word(make_item(FUNC_TICK, 7, 16'hFFFF, 10'h3FF));
		send_word(make_item(FUNC_SET, 0, 0, 0));
		send_word(make_item(FUNC_SET, 1, 16'hFFFF, 0));
		send_word(make_item(FUNC_SET, 2, 2500, 0));
		send_word(make_item(FUNC_SET, 3, 2000, 0));
		send_word(make_item(FUNC_SET, 4, 3333, 0));
		send_word(make_item(FUNC_SET, 7, 1234, 0));
		send_word(make_item(FUNC_ADC, 3, 0, 0));
		send_word(make_item(FUNC_ADC, 2, 0, 10'h3FF));
		send_word(make_item(FUNC_ADC, 1, 0, 511));
		send_word(make_item(FUNC_ADC, 5, 0, 10'h3FF));
		send_word(make_item(FUNC_ADC, 6, 0, 0));
		send_word(make_item(FUNC_NONE, 7, 16'hFFFF, 10'h3FF));
		send_word(make_item(FUNC_NONE, 0, 0, 0));
		send_word(make_item(FUNC_SET, 0, 3999, 0));
		send_word(make_item(FUNC_TICK, 2, 16'h5555, 10'h2AA));
		send_word(make_item(FUNC_TICK, 5, 16'hAAAA, 10'h155));
		send_random(60, 50);

		// Small widths and frames keep the sequencer cycling through whole
		// frames; the extremes come last so their long delays cost nothing.
		set_and_run(16'd1, 16'd9, 16'd40, 500, 85);
		set_and_run(16'd0, 16'd6, 16'd1, 300, 80);       // gap always one tick
		set_and_run(16'd12, 16'd4, 16'd30, 300, 80);     // floor above ceiling
		set_and_run(16'd0, 16'd15, 16'd64, 500, 85);
		set_and_run(16'd0, 16'hFFFF, 16'hFFFF, 150, 20);
		set_and_run(16'hFFFF, 16'd0, 16'd1, 40, 20);

		while (board.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("run covered %0d words over %0d register settings", board.words,
			settings_run);
		$display("the sequencer started %0d frames, %0d of them after a shortened gap",
			board.frames, board.short_gaps);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
